/* rtl/core/tah_pkg.sv */
// ----------------------------------------------------------------------------
// tah_pkg
// Shared constants for the thermal alarm block: field widths, register map
// and the fixed cool band thresholds in 1/16 degree.
// ----------------------------------------------------------------------------
package tah_pkg;

   // field widths
   localparam int TEMP_W  = 12;
   localparam int LIMIT_W = 7;
   localparam int PEAK_W  = 7;
   localparam int MODE_W  = 2;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_HIGH_LIMIT = 3'd0;

   // reset value of the alarm threshold, whole degrees
   localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 7'd30;

   // compare width: sample and limit-derived thresholds, signed
   localparam int CMP_W = 13;

   // fixed cool band, 24.5 and 25.5 degrees in 1/16 degree
   localparam logic signed [CMP_W-1:0] COOL_ENTER = 13'sd392;
   localparam logic signed [CMP_W-1:0] COOL_LEAVE = 13'sd408;

   // band offsets around the limit, in 1/16 degree
   localparam logic signed [CMP_W-1:0] OFS_HALF      = 13'sd8;
   localparam logic signed [CMP_W-1:0] OFS_ONE_HALF  = 13'sd24;
   localparam logic signed [CMP_W-1:0] OFS_TWO_HALF  = 13'sd40;

   // actuator codes
   localparam logic [1:0] FAN_OFF = 2'd0;
   localparam logic [1:0] FAN_LOW = 2'd1;
   localparam logic [1:0] FAN_MID = 2'd2;
   localparam logic [1:0] FAN_MAX = 2'd3;

   localparam logic [1:0] BUZ_WARNING  = 2'd0;
   localparam logic [1:0] BUZ_OVERHEAT = 2'd1;
   localparam logic [1:0] BUZ_QUIET    = 2'd2;

endpackage

/* rtl/core/thermal_alarm_hysteresis_fsm.sv */
// ----------------------------------------------------------------------------
// thermal_alarm_hysteresis_fsm
// Over-temperature alarm with hysteresis, peak capture and actuator drives.
// ----------------------------------------------------------------------------
// One temperature sample (signed, 1/16 degree) goes in per transfer and one
// result comes out per sample: the new mode (normal, warning, overheat,
// cool), fan, LED and buzzer drives, log/save pulses on overheat entry and
// exit, and the peak whole-degree value seen during overheat. A sample is
// held in an input register, evaluated against the mode and peak state
// combinationally and written to the result register, so the block takes
// one sample per cycle; the result register's handshake alone sets the
// pace when the consumer stalls. The alarm limit (whole degrees, reset 30)
// is written through the APB port at address 0; the user must write it
// only while no sample is in flight, as the block does not enforce this.
module thermal_alarm_hysteresis_fsm (
   input  logic                                clock,
   input  logic                                reset,
   // sample stream; tdata: [11:0] temp_sixteenths, rest zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tah_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result stream; tdata: [1:0] mode, [3:2] fan_speed, [4] safe_led,
   // [5] warn_led, [7:6] buzzer_mode, [8] breath_led, [9] log_pulse,
   // [10] save_pulse, [17:11] peak_degrees, rest zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tah_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tah_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tah_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tah_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [tah_pkg::MODE_W-1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_WARNING  = 2'd1,
      MODE_OVERHEAT = 2'd2,
      MODE_COOL     = 2'd3
   } mode_type;

   // configuration register
   logic [tah_pkg::LIMIT_W-1:0]              high_limit_ff;
   logic                                     csr_write;

   // input stage
   logic                                     in_valid_ff;
   logic signed [tah_pkg::TEMP_W-1:0]        in_temp_ff;

   // state
   mode_type                                 mode_ff, mode_in;
   logic [tah_pkg::PEAK_W-1:0]               peak_ff, peak_in;

   // result register
   logic                                     out_valid_ff;
   logic [tah_pkg::RSP_DATA_W-1:0]           out_data_ff, out_data_in;

   logic                                     advance;
   logic signed [tah_pkg::CMP_W-1:0]         temp_ext;
   logic signed [tah_pkg::CMP_W-1:0]         base;
   logic [tah_pkg::PEAK_W-1:0]               deg;
   logic                                     log_p, save_p;
   logic [1:0]                               fan, buz;
   logic                                     safe, warn, breath;

   // apb access, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == tah_pkg::ADDR_HIGH_LIMIT);
   assign csr_prdata = (csr_paddr == tah_pkg::ADDR_HIGH_LIMIT)
                       ? {{(tah_pkg::CSR_DATA_W-tah_pkg::LIMIT_W){1'b0}}, high_limit_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff <= tah_pkg::HIGH_LIMIT_RESET;
      end else if (csr_write) begin
         high_limit_ff <= csr_pwdata[tah_pkg::LIMIT_W-1:0];
      end
   end

   // pipeline flow: evaluate when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_temp_ff <= req_tdata[tah_pkg::TEMP_W-1:0];
      end
   end

   // thresholds and whole-degree value of the sample
   assign temp_ext = {in_temp_ff[tah_pkg::TEMP_W-1], in_temp_ff};
   assign base     = {2'b00, high_limit_ff, 4'b0000};
   assign deg      = in_temp_ff[tah_pkg::TEMP_W-1] ? '0 : in_temp_ff[10:4];

   // next mode and peak
   always_comb begin
      mode_in = mode_ff;
      peak_in = peak_ff;
      log_p   = 1'b0;
      save_p  = 1'b0;
      case (mode_ff)
         MODE_NORMAL: begin
            if (temp_ext > base + tah_pkg::OFS_HALF) begin
               mode_in = MODE_WARNING;
            end else if (temp_ext < tah_pkg::COOL_ENTER) begin
               mode_in = MODE_COOL;
            end
         end
         MODE_WARNING: begin
            if (temp_ext > base + tah_pkg::OFS_TWO_HALF) begin
               peak_in = deg;
               log_p   = 1'b1;
               mode_in = MODE_OVERHEAT;
            end else if (temp_ext < base - tah_pkg::OFS_HALF) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_OVERHEAT: begin
            // peak rises before the exit test
            if (deg > peak_ff) begin
               peak_in = deg;
            end
            if (temp_ext < base + tah_pkg::OFS_ONE_HALF) begin
               save_p  = 1'b1;
               mode_in = MODE_WARNING;
            end
         end
         default: begin
            if (temp_ext > tah_pkg::COOL_LEAVE) begin
               mode_in = MODE_NORMAL;
            end
         end
      endcase
   end

   // actuator drives from the new mode
   always_comb begin
      case (mode_in)
         MODE_COOL: begin
            fan = tah_pkg::FAN_OFF; safe = 1'b1; warn = 1'b0;
            buz = tah_pkg::BUZ_QUIET; breath = 1'b0;
         end
         MODE_NORMAL: begin
            fan = tah_pkg::FAN_LOW; safe = 1'b1; warn = 1'b0;
            buz = tah_pkg::BUZ_QUIET; breath = 1'b0;
         end
         MODE_WARNING: begin
            fan = tah_pkg::FAN_MID; safe = 1'b0; warn = 1'b1;
            buz = tah_pkg::BUZ_WARNING; breath = 1'b0;
         end
         default: begin
            fan = tah_pkg::FAN_MAX; safe = 1'b0; warn = 1'b0;
            buz = tah_pkg::BUZ_OVERHEAT; breath = 1'b1;
         end
      endcase
   end

   assign out_data_in = {6'b000000, peak_in, save_p, log_p, breath, buz,
                         warn, safe, fan, mode_in};

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         peak_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff      <= mode_in;
            peak_ff      <= peak_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
